>>> sv/life_generation_row_stencil_defines.svh
// Assertion macros shared by the Life row stencil modules.
`ifndef LIFE_GENERATION_ROW_STENCIL_DEFINES_SVH
`define LIFE_GENERATION_ROW_STENCIL_DEFINES_SVH

// Same-cycle implication, sampled on clock and ignored while reset is high.
`define LGRS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lgrs assertion failed");

// Next-cycle implication, sampled on clock and ignored while reset is high.
`define LGRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgrs assertion failed");

`endif

>>> sv/lgrs_pkg.sv
// Package with the types and constants of the Life row stencil.
`timescale 1ns / 1ps
package lgrs_pkg;

   // Field widths of the transactions.
   localparam int ROW_WIDTH     = 64;
   localparam int ROW_NUM_WIDTH = 6;

   // Default grid edge length.
   localparam int GRID_SIZE_DEFAULT = 64;

   // Result queue depth and the width of its fill level.
   localparam int QUEUE_DEPTH       = 3;
   localparam int QUEUE_LEVEL_WIDTH = 2;

   // One result transaction.
   typedef struct packed {
      logic [ROW_WIDTH-1:0]     next_row;
      logic [ROW_NUM_WIDTH-1:0] row_number;
      logic                     frame_done;
   } result_type;

   // Results produced by one accepted row, in delivery order.
   typedef struct packed {
      logic [QUEUE_LEVEL_WIDTH-1:0] count;
      result_type                   first;
      result_type                   second;
   } push_type;

   // The three vertically stacked bits of one column handed to the neighbours.
   typedef struct packed {
      logic above;
      logic middle;
      logic below;
   } column_bits_type;

endpackage

>>> sv/lgrs_req_if.sv
// Input channel interface carrying one grid row per transaction.
`timescale 1ns / 1ps
interface lgrs_req_if
   import lgrs_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ROW_WIDTH-1:0] row_cells;

   modport source (output valid, output row_cells, input ready);
   modport sink (input valid, input row_cells, output ready);
endinterface

>>> sv/lgrs_rsp_if.sv
// Result channel interface carrying one next-generation row per transaction.
`timescale 1ns / 1ps
interface lgrs_rsp_if
   import lgrs_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [ROW_WIDTH-1:0]     next_row;
   logic [ROW_NUM_WIDTH-1:0] row_number;
   logic                     frame_done;

   modport source (output valid, output next_row, output row_number, output frame_done,
                   input ready);
   modport sink (input valid, input next_row, input row_number, input frame_done,
                 output ready);
endinterface

>>> sv/life_generation_row_stencil.sv
// Top level of the streaming Life (B3/S23) generation stencil.
// Rows of the current generation enter one per transaction, top row first, and the block
// takes a row in every cycle in which the result queue has room for that row's results.
// Each row enters a chain of column cells, one per grid column, which holds the two rows
// before it; when row r is accepted the next-generation row r-1 is written into a
// three-entry result queue and is offered on the result channel once it reaches the head
// of the queue. The first row of a frame gives no result, and the last row gives two: row
// GRID_SIZE-2 and then the all-zero row GRID_SIZE-1 marked with frame_done, in that order.
// Border rows and columns and bits at or above GRID_SIZE are always zero.
`timescale 1ns / 1ps
module life_generation_row_stencil
   import lgrs_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   lgrs_req_if.sink   req_chan,
   lgrs_rsp_if.source rsp_chan
);

`include "life_generation_row_stencil_defines.svh"

   localparam logic [ROW_NUM_WIDTH-1:0] LAST_ROW = ROW_NUM_WIDTH'(GRID_SIZE - 1);

   logic [ROW_NUM_WIDTH-1:0]     rows_seen_ff;
   logic [ROW_NUM_WIDTH-1:0]     rows_seen_in;
   logic                         accept;
   logic [QUEUE_LEVEL_WIDTH-1:0] need;
   logic [QUEUE_LEVEL_WIDTH-1:0] level;
   logic [ROW_WIDTH-1:0]         stencil_row;
   push_type                     push;
   column_bits_type              column_bits [GRID_SIZE];

   // Results a row will produce, known from the row counter alone.
   always_comb begin
      need = QUEUE_LEVEL_WIDTH'(rows_seen_ff != '0) + QUEUE_LEVEL_WIDTH'(rows_seen_ff == LAST_ROW);
   end

   assign req_chan.ready = (3'(level) + 3'(need)) <= 3'(QUEUE_DEPTH);
   assign accept         = req_chan.valid && req_chan.ready;

   // Row counter, wrapping after the last row of the frame.
   always_comb begin
      rows_seen_in = rows_seen_ff;
      if (accept) begin
         rows_seen_in = (rows_seen_ff == LAST_ROW) ? '0 : rows_seen_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_seen_ff <= '0;
      end else begin
         rows_seen_ff <= rows_seen_in;
      end
   end

   // Chain of column cells; the outermost columns read dead neighbours and give dead results.
   for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_column
      if (c < GRID_SIZE) begin : g_cell
         column_bits_type left_bits;
         column_bits_type right_bits;
         logic            next_bit;

         if (c == 0) begin : g_left_edge
            assign left_bits = '0;
         end else begin : g_left_inner
            assign left_bits = column_bits[c - 1];
         end
         if (c == GRID_SIZE - 1) begin : g_right_edge
            assign right_bits = '0;
         end else begin : g_right_inner
            assign right_bits = column_bits[c + 1];
         end

         lgrs_cell u_cell (
            .clock      (clock),
            .shift      (accept),
            .below_bit  (req_chan.row_cells[c]),
            .left_bits  (left_bits),
            .right_bits (right_bits),
            .own_bits   (column_bits[c]),
            .next_bit   (next_bit)
         );

         assign stencil_row[c] = ((c == 0) || (c == GRID_SIZE - 1)) ? 1'b0 : next_bit;
      end else begin : g_outside
         assign stencil_row[c] = 1'b0;
      end
   end

   // Results of the accepted row: the previous row, and on the last row the closing border row.
   always_comb begin
      push.count             = accept ? need : '0;
      push.first.next_row    = (rows_seen_ff == 6'd1) ? '0 : stencil_row;
      push.first.row_number  = rows_seen_ff - 1'b1;
      push.first.frame_done  = 1'b0;
      push.second.next_row   = '0;
      push.second.row_number = LAST_ROW;
      push.second.frame_done = 1'b1;
   end

   lgrs_result_queue u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .level    (level),
      .rsp_chan (rsp_chan)
   );

   `LGRS_ASSERT_NEXT(last_row_wraps, accept && (rows_seen_ff == LAST_ROW), rows_seen_ff == '0)
   `LGRS_ASSERT_SAME(done_on_last_row, rsp_chan.valid && rsp_chan.frame_done, rsp_chan.row_number == LAST_ROW)
   `LGRS_ASSERT_NEXT(first_row_silent, accept && (rows_seen_ff == '0), level <= $past(level))

endmodule

>>> sv/lgrs_cell.sv
// One column cell: holds the column's two previous row bits and applies the B3/S23 rule.
`timescale 1ns / 1ps
module lgrs_cell
   import lgrs_pkg::*;
(
   input  logic            clock,
   input  logic            shift,
   input  logic            below_bit,
   input  column_bits_type left_bits,
   input  column_bits_type right_bits,
   output column_bits_type own_bits,
   output logic            next_bit
);

   logic above_ff;
   logic above_in;
   logic middle_ff;
   logic middle_in;
   logic [3:0] neighbours;

   // The column moves up one row whenever a row transaction is accepted.
   always_comb begin
      above_in  = shift ? middle_ff : above_ff;
      middle_in = shift ? below_bit : middle_ff;
   end

   always_ff @(posedge clock) begin
      above_ff  <= above_in;
      middle_ff <= middle_in;
   end

   // Hand this column's bits to both neighbours.
   assign own_bits = '{above: above_ff, middle: middle_ff, below: below_bit};

   // Count the eight neighbours and apply birth on three, survival on two or three.
   always_comb begin
      neighbours = 4'({3'b000, left_bits.above}) + 4'({3'b000, left_bits.middle})
                 + 4'({3'b000, left_bits.below}) + 4'({3'b000, above_ff})
                 + 4'({3'b000, below_bit}) + 4'({3'b000, right_bits.above})
                 + 4'({3'b000, right_bits.middle}) + 4'({3'b000, right_bits.below});
      next_bit = (neighbours == 4'd3) || ((neighbours == 4'd2) && middle_ff);
   end

endmodule

>>> sv/lgrs_result_queue.sv
// Three-entry result queue that takes up to two results per cycle and delivers one when the receiver is ready.
`timescale 1ns / 1ps
module lgrs_result_queue
   import lgrs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  push_type                     push,
   output logic [QUEUE_LEVEL_WIDTH-1:0] level,
   lgrs_rsp_if.source                   rsp_chan
);

`include "life_generation_row_stencil_defines.svh"

   result_type                   slot_ff [QUEUE_DEPTH];
   result_type                   slot_in [QUEUE_DEPTH];
   logic [QUEUE_LEVEL_WIDTH-1:0] level_ff;
   logic [QUEUE_LEVEL_WIDTH-1:0] level_in;
   logic [QUEUE_LEVEL_WIDTH-1:0] base;
   logic                         pop;

   // The head entry is always slot zero.
   assign rsp_chan.valid      = (level_ff != '0);
   assign rsp_chan.next_row   = slot_ff[0].next_row;
   assign rsp_chan.row_number = slot_ff[0].row_number;
   assign rsp_chan.frame_done = slot_ff[0].frame_done;
   assign pop                 = rsp_chan.valid && rsp_chan.ready;
   assign level               = level_ff;

   // Shift out the delivered entry, then append the new results behind the rest.
   always_comb begin
      base = level_ff - QUEUE_LEVEL_WIDTH'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i < QUEUE_DEPTH - 1)) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((push.count != '0) && (QUEUE_LEVEL_WIDTH'(i) == base)) begin
            slot_in[i] = push.first;
         end
         if ((push.count == 2'd2) && (QUEUE_LEVEL_WIDTH'(i) == base + 2'd1)) begin
            slot_in[i] = push.second;
         end
      end
      level_in = base + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   `LGRS_ASSERT_SAME(level_in_range, 1'b1, level_ff <= QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH))
   `LGRS_ASSERT_NEXT(double_push_grows, (push.count == 2'd2) && !pop, level_ff == 2'($past(level_ff) + 2'd2))
   `LGRS_ASSERT_NEXT(lone_pop_shrinks, pop && (push.count == '0), level_ff == 2'($past(level_ff) - 2'd1))

endmodule

>>> test/life_generation_row_stencil_tb.sv
// Self-checking testbench for the streaming Life generation row stencil.
`timescale 1ns / 1ps
module life_generation_row_stencil_tb
   import lgrs_pkg::*;
   ();

   localparam int GRID = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;

   typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_EMPTY, FILL_FULL} fill_kind_type;

   logic clock;
   logic reset;

   lgrs_req_if req_chan ();
   lgrs_rsp_if rsp_chan ();

   life_generation_row_stencil #(
      .GRID_SIZE(GRID)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: the two rows held back and the index of the next row.
   logic [ROW_WIDTH-1:0] grid_row_above;
   logic [ROW_WIDTH-1:0] grid_row_middle;
   int                   next_row_index;

   result_type expected_rows[$];
   result_type oldest_row;
   int         mismatch_count;
   int         cycle_count;
   int         receiver_hold_cycles;
   bit         sender_no_gaps;
   bit         receiver_no_stalls;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [ROW_WIDTH-1:0] grid_mask();
      return {ROW_WIDTH{1'b1}} >> (ROW_WIDTH - GRID);
   endfunction

   // One generation of B3/S23 for the middle row; edge columns stay dead.
   function automatic logic [ROW_WIDTH-1:0] life_next_row(input logic [ROW_WIDTH-1:0] up,
                                                          input logic [ROW_WIDTH-1:0] mid,
                                                          input logic [ROW_WIDTH-1:0] down);
      logic [ROW_WIDTH-1:0] result;
      int                   neighbours;
      result = '0;
      for (int c = 1; c < GRID - 1; c++) begin
         neighbours = up[c-1] + up[c] + up[c+1] + mid[c-1] + mid[c+1]
                    + down[c-1] + down[c] + down[c+1];
         if (neighbours == 3 || (neighbours == 2 && mid[c]))
            result[c] = 1'b1;
      end
      return result;
   endfunction

   // Works out the results that one accepted row causes and queues them.
   function automatic void predict_generation(input logic [ROW_WIDTH-1:0] cells);
      logic [ROW_WIDTH-1:0] current;
      result_type           item;
      current = cells & grid_mask();
      if (next_row_index >= 1) begin
         item.next_row   = (next_row_index == 1) ? '0
                           : life_next_row(grid_row_above, grid_row_middle, current);
         item.row_number = ROW_NUM_WIDTH'(next_row_index - 1);
         item.frame_done = 1'b0;
         expected_rows.push_back(item);
      end
      if (next_row_index == GRID - 1) begin
         // The bottom border row closes the frame.
         item.next_row   = '0;
         item.row_number = ROW_NUM_WIDTH'(next_row_index);
         item.frame_done = 1'b1;
         expected_rows.push_back(item);
         next_row_index = 0;
      end else begin
         next_row_index = next_row_index + 1;
      end
      grid_row_above  = grid_row_middle;
      grid_row_middle = current;
   endfunction

   function automatic logic [ROW_WIDTH-1:0] random_row();
      fill_kind_type kind;
      kind = fill_kind_type'($urandom_range(0, 9) < 4 ? FILL_SPARSE : $urandom_range(0, 4));
      unique case (kind)
         FILL_SPARSE: begin
            return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         end
         FILL_DENSE: begin
            return {$urandom, $urandom} | {$urandom, $urandom};
         end
         FILL_EMPTY: begin
            return '0;
         end
         FILL_FULL: begin
            return '1;
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [ROW_WIDTH-1:0] got,
                                  input logic [ROW_WIDTH-1:0] want);
      $display("ERROR at %0t: %s got %h, expected %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Offers one row after a random gap and waits for the transaction.
   task automatic send_row(input logic [ROW_WIDTH-1:0] cells);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.row_cells <= cells;
      do @(posedge clock); while (!req_chan.ready);
      predict_generation(cells);
   endtask

   // Result receiver: random stalls per transaction, plus long hold-offs on request.
   initial begin : result_receiver
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (receiver_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (receiver_hold_cycles) @(posedge clock);
            receiver_hold_cycles = 0;
         end
         stall = receiver_no_stalls ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid && receiver_hold_cycles == 0);
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rows.size() == 0) begin
            report_mismatch("result with nothing pending, next_row", rsp_chan.next_row, '0);
         end else begin
            oldest_row = expected_rows.pop_front();
            if (rsp_chan.next_row !== oldest_row.next_row)
               report_mismatch("next_row", rsp_chan.next_row, oldest_row.next_row);
            if (rsp_chan.row_number !== oldest_row.row_number)
               report_mismatch("row_number", ROW_WIDTH'(rsp_chan.row_number),
                               ROW_WIDTH'(oldest_row.row_number));
            if (rsp_chan.frame_done !== oldest_row.frame_done)
               report_mismatch("frame_done", ROW_WIDTH'(rsp_chan.frame_done),
                               ROW_WIDTH'(oldest_row.frame_done));
         end
      end
   end

   // Known shapes at the top of a frame: full and empty rows, edge columns,
   // checkerboards, a blinker, a glider and a block against the right edge.
   task automatic test_directed_patterns();
      send_row('1);
      send_row('1);
      send_row('0);
      send_row(64'h8000_0000_0000_0001);
      send_row(64'h5555_5555_5555_5555);
      send_row(64'hAAAA_AAAA_AAAA_AAAA);
      send_row('0);
      repeat (3) send_row(64'h1 << 10);
      repeat (2) send_row('0);
      send_row(64'b010 << 20);
      send_row(64'b001 << 20);
      send_row(64'b111 << 20);
      send_row('0);
      repeat (2) send_row(64'hC000_0000_0000_0000);
      send_row(64'h7FFF_FFFF_FFFF_FFFE);
      send_row('0);
   endtask

   // Rows at full rate on both sides.
   task automatic test_back_to_back(input int count);
      sender_no_gaps     = 1'b1;
      receiver_no_stalls = 1'b1;
      repeat (count) send_row(random_row());
      sender_no_gaps     = 1'b0;
      receiver_no_stalls = 1'b0;
   endtask

   // The receiver holds off long enough for the result queue to fill and stall the input.
   task automatic test_input_stall(input int count);
      sender_no_gaps       = 1'b1;
      receiver_hold_cycles = 60;
      repeat (count) send_row(random_row());
      sender_no_gaps       = 1'b0;
   endtask

   // Random rows over many frames, with random gaps on both sides.
   task automatic test_random_rows(input int count);
      repeat (count) send_row(random_row());
   endtask

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.row_cells   <= '0;
      grid_row_above       = '0;
      grid_row_middle      = '0;
      next_row_index       = 0;
      mismatch_count       = 0;
      cycle_count          = 0;
      receiver_hold_cycles = 0;
      sender_no_gaps       = 1'b0;
      receiver_no_stalls   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_patterns();
      test_back_to_back(150);
      test_input_stall(40);
      test_random_rows(1740);
      req_chan.valid <= 1'b0;

      // Drain the outstanding results, then allow for the block's latency.
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rows.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
